### rtl/pgtmap_pkg.sv
package pgtmap_pkg;

  // Field widths
  localparam int unsigned VaW       = 48;
  localparam int unsigned PaW       = 52;
  localparam int unsigned FlagW     = 12;
  localparam int unsigned EntryW    = 64;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned FramesW   = 5;
  localparam int unsigned IdxW      = 9;
  localparam int unsigned PageShift = 12;
  localparam int unsigned VpnW      = VaW - PageShift;   // 36: va bits 47..12
  localparam int unsigned BaseW     = PaW - PageShift;   // 40: pool base page number

  // Stream beat widths
  localparam int unsigned STdataW = 112;  // va, pa, page_flags
  localparam int unsigned MTdataW = 72;   // status, leaf, frames_used, pad

  // Config port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 52;
  localparam logic [CfgIdxW-1:0] REG_POOL_BASE   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ENTRY_FLAGS = 1'd1;

  localparam logic [FlagW-1:0] ENTRY_FLAGS_RST = 12'h007;

  // Request kinds (tuser)
  localparam logic REQ_MAP    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  // Memory command from walker to table store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

### rtl/pgtmap_store.sv
module pgtmap_store #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pgtmap_pkg::mem_cmd_t                   cmd_i,
  input  logic [$clog2(TABLE_FRAMES*512)-1:0]    addr_i,
  input  logic [pgtmap_pkg::EntryW-1:0]          wdata_i,
  output logic [pgtmap_pkg::EntryW-1:0]          rdata_o,
  output logic                                   clr_busy_o
);

  localparam int unsigned Depth = TABLE_FRAMES * 512;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [pgtmap_pkg::EntryW-1:0] mem [Depth];
  logic [pgtmap_pkg::EntryW-1:0] rdata_q;
  logic [AddrW-1:0]              clr_addr_q, clr_addr_d;
  logic                          clr_busy_q, clr_busy_d;
  logic                          wr_en;
  logic [AddrW-1:0]              wr_addr;
  logic [pgtmap_pkg::EntryW-1:0] wr_data;

  // Zeroing sweep after reset, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Write port: sweep wins while it runs
  assign wr_en   = clr_busy_q | cmd_i.wr_en;
  assign wr_addr = clr_busy_q ? clr_addr_q : addr_i;
  assign wr_data = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

### rtl/pgtmap_walk.sv
module pgtmap_walk #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config
  input  logic [pgtmap_pkg::BaseW-1:0]         pool_page_i,
  input  logic [pgtmap_pkg::FlagW-1:0]         entry_flags_i,
  // request
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  logic                                 req_lookup_i,
  input  logic [pgtmap_pkg::VaW-1:0]           req_va_i,
  input  logic [pgtmap_pkg::PaW-1:0]           req_pa_i,
  input  logic [pgtmap_pkg::FlagW-1:0]         req_flags_i,
  // result
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output pgtmap_pkg::status_e                  res_status_o,
  output logic [pgtmap_pkg::EntryW-1:0]        res_leaf_o,
  output logic [pgtmap_pkg::FramesW-1:0]       res_frames_o,
  // table store
  output pgtmap_pkg::mem_cmd_t                 mem_cmd_o,
  output logic [$clog2(TABLE_FRAMES*512)-1:0]  mem_addr_o,
  output logic [pgtmap_pkg::EntryW-1:0]        mem_wdata_o,
  input  logic [pgtmap_pkg::EntryW-1:0]        mem_rdata_i,
  input  logic                                 clr_busy_i
);

  localparam int unsigned FrameW  = $clog2(TABLE_FRAMES);
  localparam int unsigned CountW  = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned DiffW   = pgtmap_pkg::EntryW - pgtmap_pkg::PageShift + 1;
  localparam int unsigned BaseWp1 = pgtmap_pkg::BaseW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [1:0] LEAF_LVL = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [1:0]                     lvl_q, lvl_d;
  logic [FrameW-1:0]              frame_q, frame_d;
  logic [CountW-1:0]              next_free_q, next_free_d;
  logic                           lookup_q;
  logic [pgtmap_pkg::VpnW-1:0]    vpn_q;
  logic [pgtmap_pkg::PaW-1:0]     pa_q;
  logic [pgtmap_pkg::FlagW-1:0]   pflags_q;
  pgtmap_pkg::status_e            status_q, status_d;
  logic [pgtmap_pkg::EntryW-1:0]  leaf_q, leaf_d;
  logic                           out_valid_q, out_valid_d;
  pgtmap_pkg::status_e            out_status_q;
  logic [pgtmap_pkg::EntryW-1:0]  out_leaf_q;
  logic [pgtmap_pkg::FramesW-1:0] out_frames_q;

  logic                           accept;
  logic                           out_load;
  logic [pgtmap_pkg::IdxW-1:0]    slot_idx;
  logic [DiffW-1:0]               diff;
  logic                           outside;
  logic [BaseWp1-1:0]             new_page;
  logic [pgtmap_pkg::EntryW-1:0]  new_entry;
  logic [pgtmap_pkg::EntryW-1:0]  leaf_entry;

  assign accept   = req_valid_i & req_ready_o;
  assign out_load = (state_q == S_DONE) & (~out_valid_q | res_ready_i);

  assign req_ready_o = (state_q == S_IDLE) & ~clr_busy_i;

  // Table index for the current level
  always_comb begin
    case (lvl_q)
      2'd0:    slot_idx = vpn_q[35:27];
      2'd1:    slot_idx = vpn_q[26:18];
      2'd2:    slot_idx = vpn_q[17:9];
      default: slot_idx = vpn_q[8:0];
    endcase
  end

  assign mem_addr_o = {frame_q, slot_idx};

  // Pointer check: entry page minus pool page, borrow means below the pool
  assign diff    = {1'b0, mem_rdata_i[pgtmap_pkg::EntryW-1:pgtmap_pkg::PageShift]}
                   - DiffW'(pool_page_i);
  assign outside = diff[DiffW-1] | (diff[DiffW-2:0] >= (DiffW-1)'(TABLE_FRAMES));

  // New intermediate entry and leaf entry
  assign new_page   = BaseWp1'(pool_page_i) + BaseWp1'(next_free_q);
  assign new_entry  = {11'd0, new_page, entry_flags_i};
  assign leaf_entry = {12'd0, pa_q} | {52'd0, pflags_q};

  // Walk sequencer
  always_comb begin
    state_d         = state_q;
    lvl_d           = lvl_q;
    frame_d         = frame_q;
    next_free_d     = next_free_q;
    status_d        = status_q;
    leaf_d          = leaf_q;
    mem_cmd_o.rd_en = 1'b0;
    mem_cmd_o.wr_en = 1'b0;
    mem_wdata_o     = new_entry;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          lvl_d    = 2'd0;
          frame_d  = '0;
          status_d = pgtmap_pkg::ST_OK;
          leaf_d   = '0;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        mem_cmd_o.rd_en = 1'b1;
        state_d         = S_EVAL;
      end
      S_EVAL: begin
        if (lvl_q == LEAF_LVL) begin
          if (lookup_q == pgtmap_pkg::REQ_LOOKUP) begin
            leaf_d = mem_rdata_i;
          end else begin
            mem_cmd_o.wr_en = 1'b1;
            mem_wdata_o     = leaf_entry;
            leaf_d          = leaf_entry;
          end
          state_d = S_DONE;
        end else if (mem_rdata_i[0]) begin
          // present: follow the pointer
          if (outside) begin
            status_d = pgtmap_pkg::ST_OUTSIDE;
            state_d  = S_DONE;
          end else begin
            frame_d = diff[FrameW-1:0];
            lvl_d   = lvl_q + 2'd1;
            state_d = S_READ;
          end
        end else if (lookup_q == pgtmap_pkg::REQ_LOOKUP) begin
          status_d = pgtmap_pkg::ST_ABSENT;
          state_d  = S_DONE;
        end else if (next_free_q >= CountW'(TABLE_FRAMES)) begin
          status_d = pgtmap_pkg::ST_NO_FRAME;
          state_d  = S_DONE;
        end else begin
          // absent on map: link the next zeroed frame
          mem_cmd_o.wr_en = 1'b1;
          frame_d         = next_free_q[FrameW-1:0];
          next_free_d     = next_free_q + CountW'(1);
          lvl_d           = lvl_q + 2'd1;
          state_d         = S_READ;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      frame_q     <= '0;
      next_free_q <= CountW'(1);
      status_q    <= pgtmap_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      frame_q     <= frame_d;
      next_free_q <= next_free_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    leaf_q <= leaf_d;
    if (accept) begin
      lookup_q <= req_lookup_i;
      vpn_q    <= req_va_i[pgtmap_pkg::VaW-1:pgtmap_pkg::PageShift];
      pa_q     <= req_pa_i;
      pflags_q <= req_flags_i;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_leaf_q   <= (status_q == pgtmap_pkg::ST_OK) ? leaf_q : '0;
      out_frames_q <= pgtmap_pkg::FramesW'(next_free_q);
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_leaf_o   = out_leaf_q;
  assign res_frames_o = out_frames_q;

endmodule

### rtl/four_level_page_table_mapper.sv
// Four-level page-table mapper. Each request walks a 4-level table tree
// (9 index bits per level from va[47:12]) held in one single-port-style
// synchronous RAM of TABLE_FRAMES*512 64-bit entries; a map request
// allocates missing tables from the pool, a lookup only reads. A request
// that walks all four levels is accepted, then at each level reads the RAM
// and then checks/writes the entry through the same port, and finally
// loads the result register; an early error ends the walk sooner. After
// reset the block zeroes all TABLE_FRAMES*512 RAM entries (8192 at the
// default) and holds s_axis_tready low meanwhile; config writes are taken
// anytime. A finished result waits in an output register, so a new request
// can be accepted while the previous result is still pending.
module four_level_page_table_mapper #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pgtmap_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pgtmap_pkg::CfgDataW-1:0]       cfg_data_i,
  // request stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [pgtmap_pkg::STdataW-1:0]        s_axis_tdata,  // va[48], pa[52], page_flags[12]
  input  logic                                  s_axis_tuser,  // req_type
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [pgtmap_pkg::MTdataW-1:0]        m_axis_tdata   // status[2], leaf_entry[64],
                                                               // frames_used[5], zero pad[1]
);

  localparam int unsigned AddrW = $clog2(TABLE_FRAMES * 512);

  logic [pgtmap_pkg::CfgDataW-1:0] pool_base_q;
  logic [pgtmap_pkg::FlagW-1:0]    entry_flags_q;
  logic                            cfg_we;

  pgtmap_pkg::mem_cmd_t            mem_cmd;
  logic [AddrW-1:0]                mem_addr;
  logic [pgtmap_pkg::EntryW-1:0]   mem_wdata;
  logic [pgtmap_pkg::EntryW-1:0]   mem_rdata;
  logic                            clr_busy;

  pgtmap_pkg::status_e             res_status;
  logic [pgtmap_pkg::EntryW-1:0]   res_leaf;
  logic [pgtmap_pkg::FramesW-1:0]  res_frames;

  // Config registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      entry_flags_q <= pgtmap_pkg::ENTRY_FLAGS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        pgtmap_pkg::REG_POOL_BASE:   pool_base_q   <= cfg_data_i;
        pgtmap_pkg::REG_ENTRY_FLAGS: entry_flags_q <= cfg_data_i[pgtmap_pkg::FlagW-1:0];
        default: ;
      endcase
    end
  end

  pgtmap_walk #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pool_page_i   (pool_base_q[pgtmap_pkg::PaW-1:pgtmap_pkg::PageShift]),
    .entry_flags_i (entry_flags_q),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_lookup_i  (s_axis_tuser),
    .req_va_i      (s_axis_tdata[47:0]),
    .req_pa_i      (s_axis_tdata[99:48]),
    .req_flags_i   (s_axis_tdata[111:100]),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_status_o  (res_status),
    .res_leaf_o    (res_leaf),
    .res_frames_o  (res_frames),
    .mem_cmd_o     (mem_cmd),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata),
    .clr_busy_i    (clr_busy)
  );

  pgtmap_store #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (mem_cmd),
    .addr_i     (mem_addr),
    .wdata_i    (mem_wdata),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  assign m_axis_tdata = {1'b0, res_frames, res_leaf, res_status};

`ifndef NO_ASSERTIONS
  // walker never touches the RAM while the zeroing sweep owns it
  a_no_access_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !(mem_cmd.wr_en || mem_cmd.rd_en))
    else $error("RAM access during clearing sweep");

  // no request is taken before the sweep ends
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready)
    else $error("request accepted during clearing sweep");

  // failed walks report a zero leaf
  a_err_leaf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_status != pgtmap_pkg::ST_OK)) |-> (res_leaf == '0))
    else $error("nonzero leaf on error result");
`endif

endmodule
